[hdl/sorted_job_queue_macros.svh]
// Assertion macros for the sorted job queue RTL.
`ifndef SORTED_JOB_QUEUE_MACROS_SVH
`define SORTED_JOB_QUEUE_MACROS_SVH

// Checked only while out of reset.
`define SJQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define SJQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/sjq_pkg.sv]
// Types and constants for the sorted job queue.
package sjq_pkg;

  localparam int unsigned SJQ_DEPTH = 16;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] id;
    logic [31:0] arrival;
    logic [7:0]  serial;
    logic [31:0] runtime;
    logic [7:0]  prio;
  } job_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic push;
    logic pop;
    job_t job;
  } cell_cmd_t;

endpackage

[hdl/sorted_job_queue.sv]
// Sorted job queue top level: a row of shifting cells ordered by memory need.
//
// Input channel: in_valid_i / in_stall_o carry one transaction per accepted
// edge, either a push of a job record or a pop of the smallest-memory job.
// Output channel: out_valid_o / out_stall_i return exactly one result per
// transaction: a status code, the popped job fields (zero unless a job was
// popped) and the occupancy after the operation.
// The result lands in the output register in the cycle after acceptance.
// Throughput is one transaction per cycle unless the receiver stalls: every
// cell compares its key with the pushed key in parallel and the row shifts
// right on insert, left on pop, in that same cycle, so the cells set the rate.
// A push into a full queue and a pop of an empty one leave the queue alone and
// report it in the status.
// While the receiver stalls with a result pending, in_stall_o is raised and the
// result is held; a new transaction is taken in the cycle the result leaves.
// Reset empties the queue (fill count zero) and drops any pending result; the
// stored records need no clearing since only occupied slots are ever read.
`include "sorted_job_queue_macros.svh"

module sorted_job_queue import sjq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = SJQ_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [15:0] job_id_i,
  input  logic [31:0] arrival_i,
  input  logic [15:0] memory_need_i,
  input  logic [7:0]  serial_need_i,
  input  logic [31:0] run_length_i,
  input  logic [7:0]  job_priority_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_job_id_o,
  output logic [31:0] out_arrival_o,
  output logic [15:0] out_memory_need_o,
  output logic [7:0]  out_serial_need_o,
  output logic [31:0] out_run_length_o,
  output logic [7:0]  out_priority_o,
  output logic [4:0]  occupancy_o
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic          accept;
  logic          full, empty;
  logic [CW-1:0] count_q, count_d;
  cell_cmd_t     cmd;
  job_t          new_job;
  job_t          job_w [QUEUE_DEPTH];
  logic          t_w   [QUEUE_DEPTH];

  logic          out_valid_q, out_valid_d;
  status_e       status_q, status_d;
  job_t          out_job_q, out_job_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [CW+4:0] occ_ext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(QUEUE_DEPTH));
  assign empty      = (count_q == '0);

  assign new_job.key     = memory_need_i;
  assign new_job.id      = job_id_i;
  assign new_job.arrival = arrival_i;
  assign new_job.serial  = serial_need_i;
  assign new_job.runtime = run_length_i;
  assign new_job.prio    = job_priority_i;

  assign cmd.push = accept && (operation_i == OP_PUSH) && !full;
  assign cmd.pop  = accept && (operation_i == OP_POP) && !empty;
  assign cmd.job  = new_job;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic occ;
    logic prev_t;
    job_t left_job;
    job_t right_job;

    assign occ = (CW'(i) < count_q);

    if (i == 0) begin : g_first
      assign prev_t   = 1'b0;
      assign left_job = '0;
    end else begin : g_mid
      assign prev_t   = t_w[i-1];
      assign left_job = job_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_job = '0;
    end else begin : g_notlast
      assign right_job = job_w[i+1];
    end

    sjq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occ_i       (occ),
      .prev_t_i    (prev_t),
      .left_job_i  (left_job),
      .right_job_i (right_job),
      .t_o         (t_w[i]),
      .job_o       (job_w[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd.push) begin
      count_d = count_q + 1'b1;
    end else if (cmd.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    out_job_d   = out_job_q;
    occ_d       = occ_q;
    if (accept) begin
      out_valid_d = 1'b1;
      out_job_d   = '0;
      occ_d       = count_d;
      if (operation_i == OP_PUSH) begin
        status_d = full ? ST_FULL : ST_PUSHED;
      end else if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        status_d  = ST_POPPED;
        out_job_d = job_w[0];
      end
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    out_job_q <= out_job_d;
    occ_q     <= occ_d;
  end

  assign occ_ext = {5'b0, occ_q};

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign out_job_id_o      = out_job_q.id;
  assign out_arrival_o     = out_job_q.arrival;
  assign out_memory_need_o = out_job_q.key;
  assign out_serial_need_o = out_job_q.serial;
  assign out_run_length_o  = out_job_q.runtime;
  assign out_priority_o    = out_job_q.prio;
  assign occupancy_o       = occ_ext[4:0];

  `SJQ_ASSERT(a_count_bound, (count_q <= CW'(QUEUE_DEPTH)), "fill count beyond depth")
  `SJQ_ASSERT(a_push_grows, (cmd.push |=> (count_q == $past(count_q) + 1'b1)), "push lost")
  `SJQ_ASSERT(a_empty_zero, ((out_valid_q && (status_q == ST_EMPTY)) |-> (occ_q == '0)), "empty pop with jobs held")
  // The flop is checked as clear only from the edge after reset is sampled low.
  `SJQ_ASSERT_ALWAYS(a_rst_clear, (!rst_ni |=> !out_valid_q), "result pending in reset")

endmodule

[hdl/sjq_cell.sv]
// One slot of the sorted row: holds a job and shifts with its neighbours.
module sjq_cell import sjq_pkg::*; (
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      occ_i,
  input  logic      prev_t_i,
  input  job_t      left_job_i,
  input  job_t      right_job_i,
  output logic      t_o,
  output job_t      job_o
);

  job_t job_q, job_d;
  logic t;

  // An empty slot or a key not below the new one marks the insertion point
  // or a slot that moves right.
  assign t = !occ_i || (job_q.key >= cmd_i.job.key);

  always_comb begin
    job_d = job_q;
    if (cmd_i.push) begin
      if (t && !prev_t_i) begin
        job_d = cmd_i.job;
      end else if (prev_t_i) begin
        job_d = left_job_i;
      end
    end else if (cmd_i.pop) begin
      job_d = right_job_i;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign t_o   = t;
  assign job_o = job_q;

endmodule

[tb/tb_sorted_job_queue.sv]
// Self-checking testbench for the sorted job queue, with a golden sorted-list predictor.
module tb_sorted_job_queue;
  import sjq_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 600;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned HOLD_OFF_LEN   = 64;
  localparam int unsigned DRAIN_CYCLES   = 4;

  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_e;
  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    status_e    status;
    job_t       job;
    logic [4:0] occ;
  } job_result_t;

  typedef struct packed {
    logic       op;
    job_t       job;
    logic       typed;   // expectation written into the row
    status_e    status;
    logic [4:0] occ;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = OP_PUSH;
  logic [15:0] job_id_i = '0;
  logic [31:0] arrival_i = '0;
  logic [15:0] memory_need_i = '0;
  logic [7:0]  serial_need_i = '0;
  logic [31:0] run_length_i = '0;
  logic [7:0]  job_priority_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] out_job_id_o;
  logic [31:0] out_arrival_o;
  logic [15:0] out_memory_need_o;
  logic [7:0]  out_serial_need_o;
  logic [31:0] out_run_length_o;
  logic [7:0]  out_priority_o;
  logic [4:0]  occupancy_o;

  // travels with the transaction so the monitor can pick a written expectation
  logic        row_typed = 1'b0;
  status_e     row_status = ST_PUSHED;
  logic [4:0]  row_occupancy = '0;

  job_t          sorted_jobs [SJQ_DEPTH];
  int unsigned   jobs_held = 0;
  job_result_t   pending_results [$];
  job_result_t   predicted;
  stim_row_t     directed_rows [$];
  int unsigned   mismatch_count = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   burst_left = 0;

  sorted_job_queue i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .job_id_i         (job_id_i),
    .arrival_i        (arrival_i),
    .memory_need_i    (memory_need_i),
    .serial_need_i    (serial_need_i),
    .run_length_i     (run_length_i),
    .job_priority_i   (job_priority_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .out_job_id_o     (out_job_id_o),
    .out_arrival_o    (out_arrival_o),
    .out_memory_need_o(out_memory_need_o),
    .out_serial_need_o(out_serial_need_o),
    .out_run_length_o (out_run_length_o),
    .out_priority_o   (out_priority_o),
    .occupancy_o      (occupancy_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sorted insertion ahead of the first key >= new key, pop from the front.
  function automatic job_result_t apply_job_op(logic op, job_t job);
    job_result_t res;
    int unsigned pos;
    int unsigned i;
    logic        found;
    res.status = ST_PUSHED;
    res.job    = '0;
    found      = 1'b0;
    if (op == OP_PUSH) begin
      if (jobs_held >= SJQ_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = jobs_held;
        for (i = 0; i < jobs_held; i++) begin
          if (!found && sorted_jobs[i].key >= job.key) begin
            pos   = i;
            found = 1'b1;
          end
        end
        for (i = jobs_held; i > pos; i--) sorted_jobs[i] = sorted_jobs[i-1];
        sorted_jobs[pos] = job;
        jobs_held++;
      end
    end else if (jobs_held == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.status = ST_POPPED;
      res.job    = sorted_jobs[0];
      for (i = 1; i < jobs_held; i++) sorted_jobs[i-1] = sorted_jobs[i];
      jobs_held--;
    end
    res.occ = jobs_held[4:0];
    return res;
  endfunction

  function automatic job_t make_job(logic [15:0] id, logic [31:0] arrival, logic [15:0] key,
                                    logic [7:0] serial, logic [31:0] runtime,
                                    logic [7:0] prio);
    job_t job;
    job.key     = key;
    job.id      = id;
    job.arrival = arrival;
    job.serial  = serial;
    job.runtime = runtime;
    job.prio    = prio;
    return job;
  endfunction

  task automatic add_row(logic op, job_t job, logic typed, status_e status, logic [4:0] occ);
    stim_row_t row;
    row.op     = op;
    row.job    = job;
    row.typed  = typed;
    row.status = status;
    row.occ    = occ;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed_rows();
    job_t        zero_job;
    job_t        ones_job;
    int unsigned k;
    zero_job = make_job(16'h0, 32'h0, 16'h0, 8'h0, 32'h0, 8'h0);
    ones_job = make_job(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    add_row(OP_POP,  zero_job, 1'b1, ST_EMPTY,  5'd0);
    add_row(OP_PUSH, ones_job, 1'b1, ST_PUSHED, 5'd1);
    add_row(OP_PUSH, zero_job, 1'b1, ST_PUSHED, 5'd2);
    // equal keys: the later one must come out first
    add_row(OP_PUSH, make_job(16'd1, 32'd10, 16'h0100, 8'd1, 32'd100, 8'd7),
            1'b0, ST_PUSHED, 5'd0);
    add_row(OP_PUSH, make_job(16'd2, 32'd11, 16'h0100, 8'd2, 32'd200, 8'd3),
            1'b0, ST_PUSHED, 5'd0);
    add_row(OP_POP, zero_job, 1'b0, ST_PUSHED, 5'd0);
    add_row(OP_POP, zero_job, 1'b0, ST_PUSHED, 5'd0);
    // top up to a full queue, alternating low keys and the largest key
    for (k = 0; k < 14; k++) begin
      add_row(OP_PUSH, make_job(16'(16'h10 + k), 32'(k * 3), (k % 2) ? 16'hFFFF : 16'(k),
                                8'(k), 32'(1000 + k), 8'(255 - k)),
              1'b0, ST_PUSHED, 5'd0);
    end
    add_row(OP_PUSH, ones_job, 1'b1, ST_FULL, 5'd16);
    for (k = 0; k < 3; k++) add_row(OP_POP, zero_job, 1'b0, ST_PUSHED, 5'd0);
  endtask

  // Bursts of back-to-back transactions separated by random gaps.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap        = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic offer(stim_row_t row);
    in_valid_i     <= 1'b1;
    operation_i    <= row.op;
    job_id_i       <= row.job.id;
    arrival_i      <= row.job.arrival;
    memory_need_i  <= row.job.key;
    serial_need_i  <= row.job.serial;
    run_length_i   <= row.job.runtime;
    job_priority_i <= row.job.prio;
    row_typed      <= row.typed;
    row_status     <= row.status;
    row_occupancy  <= row.occ;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic stim_row_t random_row(traffic_mix_e mix);
    stim_row_t   row;
    int unsigned push_pct;
    int unsigned pick;
    case (mix)
      MIX_FILL:  push_pct = 80;
      MIX_DRAIN: push_pct = 20;
      default:   push_pct = 50;
    endcase
    row.op  = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
    row.job = make_job(16'($urandom), $urandom, 16'($urandom), 8'($urandom),
                       $urandom, 8'($urandom));
    // small keys make ties common
    pick = $urandom_range(0, 9);
    if (pick < 5)       row.job.key = 16'($urandom_range(0, 7));
    else if (pick == 5) row.job.key = 16'h0000;
    else if (pick == 6) row.job.key = 16'hFFFF;
    row.typed  = 1'b0;
    row.status = ST_PUSHED;
    row.occ    = '0;
    return row;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: results are checked before the new transaction is queued.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no transaction outstanding");
          mismatch_count++;
        end else begin
          predicted = pending_results.pop_front();
          compare_field("status", 32'(predicted.status), 32'(status_o));
          compare_field("out_job_id", 32'(predicted.job.id), 32'(out_job_id_o));
          compare_field("out_arrival", predicted.job.arrival, out_arrival_o);
          compare_field("out_memory_need", 32'(predicted.job.key), 32'(out_memory_need_o));
          compare_field("out_serial_need", 32'(predicted.job.serial), 32'(out_serial_need_o));
          compare_field("out_run_length", predicted.job.runtime, out_run_length_o);
          compare_field("out_priority", 32'(predicted.job.prio), 32'(out_priority_o));
          compare_field("occupancy", 32'(predicted.occ), 32'(occupancy_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predicted = apply_job_op(operation_i, make_job(job_id_i, arrival_i, memory_need_i,
                                                       serial_need_i, run_length_i,
                                                       job_priority_i));
        if (row_typed) begin
          predicted.status = row_status;
          predicted.job    = '0;
          predicted.occ    = row_occupancy;
        end
        pending_results.push_back(predicted);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** sorted_job_queue: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: its own stall pattern, with two long hold-offs that back the queue up.
  initial begin
    int unsigned rx_cycle;
    int unsigned hold_left;
    int unsigned seg_left;
    rx_mode_e    rx_mode;
    rx_cycle  = 0;
    hold_left = 0;
    seg_left  = 0;
    rx_mode   = RX_FREE;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle == 200 || rx_cycle == 1200) hold_left = HOLD_OFF_LEN;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          rx_mode  = rx_mode_e'($urandom_range(0, 2));
          seg_left = $urandom_range(10, 60);
        end
        seg_left--;
        case (rx_mode)
          RX_FREE:   out_stall_i <= 1'b0;
          RX_RANDOM: out_stall_i <= ($urandom_range(0, 99) < 40);
          default:   out_stall_i <= (rx_cycle % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    traffic_mix_e mix;
    int unsigned  mix_left;
    int unsigned  n;
    mix      = MIX_FILL;
    mix_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    build_directed_rows();
    foreach (directed_rows[r]) begin
      pace_sender();
      offer(directed_rows[r]);
    end
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (mix_left == 0) begin
        mix      = traffic_mix_e'($urandom_range(0, 2));
        mix_left = $urandom_range(20, 60);
      end
      mix_left--;
      pace_sender();
      offer(random_row(mix));
    end
    in_valid_i <= 1'b0;
    // let the monitor queue the last transaction before watching the queue drain
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** sorted_job_queue: PASSED **");
    end else begin
      $display("** sorted_job_queue: FAILED **");
    end
    $finish;
  end

endmodule

[sorted_job_queue.f]
+incdir+hdl
hdl/sjq_pkg.sv
hdl/sjq_cell.sv
hdl/sorted_job_queue.sv
tb/tb_sorted_job_queue.sv
